// ===== design/vpa_pkg.sv =====
// Shared types and codes of the variable partition allocator.
package vpa_pkg;

    localparam int unsigned BLK_IDX_W   = 6;
    localparam int unsigned OWNER_W     = 16;
    localparam int unsigned REQ_SIZE_W  = 16;
    localparam logic [31:0] RESET_TOTAL = 32'd1000;
    localparam logic [OWNER_W-1:0] ID_MAX = 16'hFFFF;
    localparam logic [OWNER_W-1:0] ID_FIRST = 16'd1;

    localparam logic [2:0] FN_FIRST = 3'd0;
    localparam logic [2:0] FN_BEST  = 3'd1;
    localparam logic [2:0] FN_WORST = 3'd2;
    localparam logic [2:0] FN_NEXT  = 3'd3;
    localparam logic [2:0] FN_FREE  = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_NOOWNER = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [2:0]            func;
        logic [REQ_SIZE_W-1:0] req_size;
        logic [OWNER_W-1:0]    owner_to_free;
    } t_req;

    typedef struct packed {
        logic [1:0]           status;
        logic [OWNER_W-1:0]   granted_owner;
        logic [BLK_IDX_W-1:0] block_index;
    } t_res;

endpackage

// ===== design/vpa_table.sv =====
// Partition table storage: one write port, one registered read port.
module vpa_table #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 33,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/variable_partition_allocator.sv =====
// Top level of the variable partition allocator: sequencer over the partition table.
//
// One request is taken while busy is low; its result appears on o_res with o_done high for
// exactly one cycle and cannot be held off. Every step goes through the partition
// table, which has one write port and one registered read port. An allocation scans the
// entries for a fit, then shifts every entry above the split point up by one, then closes
// the split and writes the grant (only the grant when the fit is exact). A free scans the
// entries to find the owner, then makes one merge pass over all entries. Unknown
// functions and a zero-size allocation are answered straight from idle. A new request
// can be taken during the strobe cycle. Writing the region size rebuilds the table in the
// same cycle.
module variable_partition_allocator
    import vpa_pkg::*;
#(
    parameter int MAX_PARTS = 64,
    parameter int SIZE_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_req                 i_req,
    input  logic                 i_cfg_we,
    input  logic [SIZE_BITS-1:0] i_cfg_wdata,
    output logic                 o_done,
    output t_res                 o_res
);

    localparam int IDX_W = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
    localparam int CNT_W = $clog2(MAX_PARTS + 1);
    localparam int ENT_W = SIZE_BITS + 1 + OWNER_W;

    typedef struct packed {
        logic [SIZE_BITS-1:0] size;
        logic                 free;
        logic [OWNER_W-1:0]   owner;
    } t_entry;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_SRD   = 12'b0000_0000_0010,
        S_SEV   = 12'b0000_0000_0100,
        S_MRD   = 12'b0000_0000_1000,
        S_MWR   = 12'b0000_0001_0000,
        S_SPLIT = 12'b0000_0010_0000,
        S_TAKE  = 12'b0000_0100_0000,
        S_FRD   = 12'b0000_1000_0000,
        S_FEV   = 12'b0001_0000_0000,
        S_GRD   = 12'b0010_0000_0000,
        S_GEV   = 12'b0100_0000_0000,
        S_GEND  = 12'b1000_0000_0000
    } t_state;

    t_state               r_state, n_state;
    logic [2:0]           r_func, n_func;
    logic [SIZE_BITS-1:0] r_need, n_need;
    logic [OWNER_W-1:0]   r_pid, n_pid;
    logic [IDX_W-1:0]     r_i, n_i;
    logic [CNT_W-1:0]     r_k, n_k;
    logic                 r_found, n_found;
    logic [IDX_W-1:0]     r_pick, n_pick;
    logic [SIZE_BITS-1:0] r_psize, n_psize;
    logic [CNT_W-1:0]     r_j, n_j;
    logic [IDX_W-1:0]     r_w, n_w;
    t_entry               r_acc, n_acc;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [IDX_W-1:0]     r_cursor, n_cursor;
    logic [OWNER_W-1:0]   r_id, n_id;
    logic [1:0]           r_status, n_status;
    logic [IDX_W-1:0]     r_index, n_index;
    logic                 r_done, n_done;
    t_res                 r_res, n_res;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    t_entry           mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    logic [ENT_W-1:0] mem_rdata;
    t_entry           rd;

    logic             seq_we;
    logic [IDX_W-1:0] seq_waddr;
    t_entry           seq_wdata;

    logic [SIZE_BITS-1:0] req_need;
    logic [CNT_W-1:0]     i_next;
    logic                 fit;
    logic                 better;
    logic                 last;

    vpa_table #(
        .DEPTH (MAX_PARTS),
        .WIDTH (ENT_W),
        .AW    (IDX_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd       = t_entry'(mem_rdata);
    assign req_need = SIZE_BITS'(i_req.req_size);
    assign busy     = (r_state != S_IDLE) || !i_rst_n;
    assign o_done   = r_done;
    assign o_res    = r_res;

    // Reset and region size writes rebuild entry 0; everything else comes from the sequencer.
    always_comb begin
        if (!i_rst_n) begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = '{size: SIZE_BITS'(RESET_TOTAL), free: 1'b1, owner: '0};
        end else if (i_cfg_we) begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = '{size: i_cfg_wdata, free: 1'b1, owner: '0};
        end else begin
            mem_we    = seq_we;
            mem_waddr = seq_waddr;
            mem_wdata = seq_wdata;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_func    = r_func;
        n_need    = r_need;
        n_pid     = r_pid;
        n_i       = r_i;
        n_k       = r_k;
        n_found   = r_found;
        n_pick    = r_pick;
        n_psize   = r_psize;
        n_j       = r_j;
        n_w       = r_w;
        n_acc     = r_acc;
        n_count   = r_count;
        n_cursor  = r_cursor;
        n_id      = r_id;
        n_status  = r_status;
        n_index   = r_index;
        n_done    = 1'b0;
        n_res     = r_res;
        seq_we    = 1'b0;
        seq_waddr = '0;
        seq_wdata = '0;
        mem_raddr = r_i;

        fit    = rd.free && (rd.size >= r_need);
        better = !r_found || ((r_func == FN_BEST) && (rd.size < r_psize))
                 || ((r_func == FN_WORST) && (rd.size > r_psize));
        last   = (CNT_W'(r_i) + CNT_W'(1)) == r_count;
        i_next = CNT_W'(r_i) + CNT_W'(1);

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_func = i_req.func;
                    n_need = req_need;
                    n_pid  = i_req.owner_to_free;
                    if ((i_req.func <= FN_NEXT) && (req_need != '0)) begin
                        n_i     = ((i_req.func == FN_NEXT) && (CNT_W'(r_cursor) < r_count))
                                  ? r_cursor : '0;
                        n_k     = '0;
                        n_found = 1'b0;
                        n_state = S_SRD;
                    end else if (i_req.func == FN_FREE) begin
                        n_i      = '0;
                        n_status = ST_NOOWNER;
                        n_index  = '0;
                        n_state  = S_FRD;
                    end else begin
                        n_done = 1'b1;
                        n_res  = '{status: ST_NOFIT, granted_owner: '0, block_index: '0};
                    end
                end
            end
            S_SRD: begin
                n_state = S_SEV;
            end
            S_SEV: begin
                if (fit && better) begin
                    n_pick  = r_i;
                    n_psize = rd.size;
                    n_found = 1'b1;
                end
                if ((fit && ((r_func == FN_FIRST) || (r_func == FN_NEXT)))
                    || ((r_k + CNT_W'(1) == r_count) && (r_found || (fit && better)))) begin
                    // Take the pick: split if larger than the request; full table: ST_FULL.
                    if (n_psize > r_need) begin
                        if (r_count >= CNT_W'(MAX_PARTS)) begin
                            n_done  = 1'b1;
                            n_res   = '{status: ST_FULL, granted_owner: '0, block_index: '0};
                            n_state = S_IDLE;
                        end else begin
                            n_j     = r_count;
                            n_state = S_MRD;
                        end
                    end else begin
                        n_state = S_TAKE;
                    end
                end else if (r_k + CNT_W'(1) == r_count) begin
                    n_done  = 1'b1;
                    n_res   = '{status: ST_NOFIT, granted_owner: '0, block_index: '0};
                    n_state = S_IDLE;
                end else begin
                    n_k = r_k + CNT_W'(1);
                    if ((r_func == FN_NEXT) && (i_next >= r_count)) begin
                        n_i = '0;
                    end else begin
                        n_i = IDX_W'(i_next);
                    end
                    n_state = S_SRD;
                end
            end
            S_MRD: begin
                // Shift entries above the pick up by one, top first.
                mem_raddr = IDX_W'(r_j - CNT_W'(1));
                if (r_j > CNT_W'(r_pick) + CNT_W'(1)) begin
                    n_state = S_MWR;
                end else begin
                    n_state = S_SPLIT;
                end
            end
            S_MWR: begin
                seq_we    = 1'b1;
                seq_waddr = IDX_W'(r_j);
                seq_wdata = rd;
                n_j       = r_j - CNT_W'(1);
                n_state   = S_MRD;
            end
            S_SPLIT: begin
                seq_we    = 1'b1;
                seq_waddr = IDX_W'(CNT_W'(r_pick) + CNT_W'(1));
                seq_wdata = '{size: r_psize - r_need, free: 1'b1, owner: '0};
                n_count   = r_count + CNT_W'(1);
                n_state   = S_TAKE;
            end
            S_TAKE: begin
                seq_we    = 1'b1;
                seq_waddr = r_pick;
                seq_wdata = '{size: r_need, free: 1'b0, owner: r_id};
                n_done    = 1'b1;
                n_res     = '{status: ST_OK, granted_owner: r_id,
                              block_index: BLK_IDX_W'(r_pick)};
                n_id      = (r_id == ID_MAX) ? ID_FIRST : r_id + OWNER_W'(1);
                if (r_func == FN_NEXT) begin
                    n_cursor = r_pick;
                end
                n_state   = S_IDLE;
            end
            S_FRD: begin
                n_state = S_FEV;
            end
            S_FEV: begin
                if (!rd.free && (rd.owner == r_pid)) begin
                    seq_we    = 1'b1;
                    seq_waddr = r_i;
                    seq_wdata = '{size: rd.size, free: 1'b1, owner: '0};
                    n_status  = ST_OK;
                    n_index   = r_i;
                    n_i       = '0;
                    n_w       = '0;
                    n_state   = S_GRD;
                end else if (last) begin
                    n_i     = '0;
                    n_w     = '0;
                    n_state = S_GRD;
                end else begin
                    n_i     = IDX_W'(i_next);
                    n_state = S_FRD;
                end
            end
            S_GRD: begin
                n_state = S_GEV;
            end
            S_GEV: begin
                // Compact in place: fold runs of free entries into one.
                if (r_i == '0) begin
                    n_acc = rd;
                end else if (r_acc.free && rd.free) begin
                    n_acc.size = r_acc.size + rd.size;
                end else begin
                    seq_we    = 1'b1;
                    seq_waddr = r_w;
                    seq_wdata = r_acc;
                    n_w       = r_w + IDX_W'(1);
                    n_acc     = rd;
                end
                if (last) begin
                    n_state = S_GEND;
                end else begin
                    n_i     = IDX_W'(i_next);
                    n_state = S_GRD;
                end
            end
            S_GEND: begin
                seq_we    = 1'b1;
                seq_waddr = r_w;
                seq_wdata = r_acc;
                n_count   = CNT_W'(r_w) + CNT_W'(1);
                n_done    = 1'b1;
                n_res     = '{status: r_status, granted_owner: '0,
                              block_index: BLK_IDX_W'(r_index)};
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= CNT_W'(1);
            r_cursor <= '0;
            r_id     <= ID_FIRST;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_id     <= n_id;
            r_done   <= n_done;
            if (i_cfg_we) begin
                r_count <= CNT_W'(1);
            end else begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_need   <= n_need;
        r_pid    <= n_pid;
        r_i      <= n_i;
        r_k      <= n_k;
        r_found  <= n_found;
        r_pick   <= n_pick;
        r_psize  <= n_psize;
        r_j      <= n_j;
        r_w      <= n_w;
        r_acc    <= n_acc;
        r_status <= n_status;
        r_index  <= n_index;
        r_res    <= n_res;
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= CNT_W'(MAX_PARTS)))
        else $error("partition count out of range");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_state == S_IDLE))
        else $error("result strobe while a request is in flight");

    a_scan_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SEV) || (r_state == S_FEV) || (r_state == S_GEV))
        |-> (CNT_W'(r_i) < r_count))
        else $error("table read beyond the last partition");

    a_id_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_id != '0)
        else $error("owner id counter reached zero");

endmodule

// ===== test/tb_variable_partition_allocator.sv =====
// Self-checking testbench for the variable partition allocator: directed table, then random traffic.
module tb_variable_partition_allocator;
    import vpa_pkg::*;

    localparam int NPARTS    = 64;
    localparam int DRAIN     = 300;
    localparam int WDOG_MAX  = 20000;
    localparam int NUM_SEGS  = 6;
    localparam int SEG_ITEMS = 290;

    typedef struct {
        t_req req;
        bit   typed;
        t_res want;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_req                  i_req = '0;
    logic                  i_cfg_we = 1'b0;
    logic [REQ_SIZE_W-1:0] i_cfg_wdata = '0;
    logic                  o_done;
    t_res                  o_res;

    // Allocator model state
    logic [15:0]        region_size;
    logic [15:0]        part_len [NPARTS];
    bit                 part_avail [NPARTS];
    logic [OWNER_W-1:0] part_id [NPARTS];
    int                 nparts;
    int                 nf_cursor;
    logic [OWNER_W-1:0] next_id;

    t_res pending_res[$];
    int   fail_cnt = 0;
    int   quiet_cycles = 0;
    int   gap_pct = 0;

    variable_partition_allocator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_res       (o_res)
    );

    always #4 i_clk = ~i_clk;

    function automatic void rebuild_table();
        for (int i = 0; i < NPARTS; i++) begin
            part_len[i]   = '0;
            part_avail[i] = 1'b0;
            part_id[i]    = '0;
        end
        part_len[0]   = region_size;
        part_avail[0] = 1'b1;
        nparts        = 1;
    endfunction

    function automatic bit can_hold(int i, int need);
        return part_avail[i] && (int'(part_len[i]) >= need);
    endfunction

    function automatic void merge_neighbors();
        int i;
        i = 0;
        while (i + 1 < nparts) begin
            if (part_avail[i] && part_avail[i+1]) begin
                part_len[i] = part_len[i] + part_len[i+1];
                for (int j = i + 1; j + 1 < nparts; j++) begin
                    part_len[j]   = part_len[j+1];
                    part_avail[j] = part_avail[j+1];
                    part_id[j]    = part_id[j+1];
                end
                nparts--;
                part_len[nparts]   = '0;
                part_avail[nparts] = 1'b0;
                part_id[nparts]    = '0;
            end else begin
                i++;
            end
        end
    endfunction

    // Apply one request to the model and return the answer it owes
    function automatic t_res allocate_or_release(t_req r);
        t_res res;
        int   need;
        int   i;
        int   pick;
        bit   found;
        res   = '{status: ST_NOFIT, granted_owner: '0, block_index: '0};
        need  = r.req_size;
        pick  = 0;
        found = 1'b0;
        if (r.func <= FN_NEXT && need != 0) begin
            if (r.func == FN_NEXT) begin
                i = (nf_cursor < nparts) ? nf_cursor : 0;
                for (int k = 0; k < nparts; k++) begin
                    if (can_hold(i, need)) begin
                        pick  = i;
                        found = 1'b1;
                        break;
                    end
                    i = (i + 1 >= nparts) ? 0 : i + 1;
                end
            end else begin
                for (i = 0; i < nparts; i++) begin
                    if (!can_hold(i, need))
                        continue;
                    if (!found || (r.func == FN_BEST && part_len[i] < part_len[pick]) ||
                        (r.func == FN_WORST && part_len[i] > part_len[pick])) begin
                        pick  = i;
                        found = 1'b1;
                        if (r.func == FN_FIRST)
                            break;
                    end
                end
            end
            if (found) begin
                if (int'(part_len[pick]) > need && nparts >= NPARTS) begin
                    res.status = ST_FULL;
                end else begin
                    if (int'(part_len[pick]) > need) begin
                        for (int j = nparts; j > pick + 1; j--) begin
                            part_len[j]   = part_len[j-1];
                            part_avail[j] = part_avail[j-1];
                            part_id[j]    = part_id[j-1];
                        end
                        part_len[pick+1]   = part_len[pick] - REQ_SIZE_W'(need);
                        part_avail[pick+1] = 1'b1;
                        part_id[pick+1]    = '0;
                        part_len[pick]     = REQ_SIZE_W'(need);
                        nparts++;
                    end
                    part_avail[pick] = 1'b0;
                    part_id[pick]    = next_id;
                    res = '{status: ST_OK, granted_owner: next_id,
                            block_index: BLK_IDX_W'(pick)};
                    next_id = (next_id >= ID_MAX) ? ID_FIRST : next_id + 1'b1;
                    if (r.func == FN_NEXT)
                        nf_cursor = pick;
                end
            end
        end else if (r.func == FN_FREE) begin
            res.status = ST_NOOWNER;
            for (i = 0; i < nparts; i++) begin
                if (!part_avail[i] && part_id[i] == r.owner_to_free) begin
                    part_avail[i]   = 1'b1;
                    part_id[i]      = '0;
                    res.status      = ST_OK;
                    res.block_index = BLK_IDX_W'(i);
                    break;
                end
            end
            merge_neighbors();
        end
        return res;
    endfunction

    // Hold start high until the block takes the transaction
    task automatic issue(t_req r, bit typed, t_res want);
        t_res res;
        i_req <= r;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        res = allocate_or_release(r);
        pending_res.insert(pending_res.size(), typed ? want : res);
    endtask

    // Idle the sender cycle by cycle with probability gap_pct
    task automatic maybe_pause();
        while ($urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic write_region(logic [15:0] sz);
        start <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= sz;
        @(posedge i_clk);
        region_size = sz;
        rebuild_table();
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_req random_request();
        t_req r;
        int   roll;
        int   cap;
        int   live [$];
        r    = '{func: FN_FIRST, req_size: REQ_SIZE_W'($urandom()),
                 owner_to_free: OWNER_W'($urandom())};
        roll = $urandom_range(0, 99);
        cap  = (region_size / 48 > 1) ? region_size / 48 : 1;
        if (roll < 7) begin
            r.func = 3'($urandom_range(5, 7));
        end else if (roll < 10) begin
            r.func     = 3'($urandom_range(0, 3));
            r.req_size = '0;
        end else if (roll < 40) begin
            r.func = FN_FREE;
            for (int i = 0; i < nparts; i++)
                if (!part_avail[i])
                    live.insert(live.size(), int'(part_id[i]));
            if (live.size() != 0 && $urandom_range(0, 9) < 8)
                r.owner_to_free = OWNER_W'(live[$urandom_range(0, live.size() - 1)]);
        end else begin
            r.func = 3'($urandom_range(0, 3));
            if ($urandom_range(0, 19) != 0)
                r.req_size = REQ_SIZE_W'($urandom_range(1, cap));
        end
        return r;
    endfunction

    // Compare every result with the oldest expectation
    always @(posedge i_clk) begin
        t_res want;
        if (o_done) begin
            if (pending_res.size() == 0) begin
                $error("unexpected result status=%0d owner=%0d index=%0d",
                       o_res.status, o_res.granted_owner, o_res.block_index);
                fail_cnt++;
            end else begin
                want = pending_res.pop_front();
                if (o_res.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_res.status);
                    fail_cnt++;
                end
                if (o_res.granted_owner !== want.granted_owner) begin
                    $error("granted_owner: expected %0d, actual %0d",
                           want.granted_owner, o_res.granted_owner);
                    fail_cnt++;
                end
                if (o_res.block_index !== want.block_index) begin
                    $error("block_index: expected %0d, actual %0d",
                           want.block_index, o_res.block_index);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || i_cfg_we || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WDOG_MAX) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        t_row rows [$];
        t_res nofit;
        t_res none;
        logic [15:0] regions [NUM_SEGS];
        nofit   = '{status: ST_NOFIT, granted_owner: '0, block_index: '0};
        none    = '{status: ST_NOOWNER, granted_owner: '0, block_index: '0};
        regions = '{16'd65535, 16'd1, 16'd300, 16'd1000, 16'd40000, 16'd200};

        rows.insert(rows.size(), '{'{FN_FIRST, 16'd0, 16'd0}, 1, nofit});
        rows.insert(rows.size(), '{'{3'd5, 16'd10, 16'd1}, 1, nofit});
        rows.insert(rows.size(), '{'{3'd7, 16'hFFFF, 16'hFFFF}, 1, nofit});
        rows.insert(rows.size(), '{'{FN_FREE, 16'd5, 16'd0}, 1, none});
        rows.insert(rows.size(), '{'{FN_FIRST, 16'hFFFF, 16'd0}, 1, nofit});
        rows.insert(rows.size(), '{'{FN_FIRST, 16'd100, 16'hFFFF}, 1, '{ST_OK, 16'd1, 6'd0}});
        rows.insert(rows.size(), '{'{FN_BEST, 16'd200, 16'd0}, 0, nofit});
        rows.insert(rows.size(), '{'{FN_WORST, 16'd50, 16'd0}, 0, nofit});
        rows.insert(rows.size(), '{'{FN_NEXT, 16'd10, 16'd0}, 0, nofit});
        rows.insert(rows.size(), '{'{FN_FREE, 16'd0, 16'd1}, 0, nofit});
        rows.insert(rows.size(), '{'{FN_BEST, 16'd100, 16'd0}, 0, nofit});
        rows.insert(rows.size(), '{'{FN_NEXT, 16'd30, 16'd0}, 0, nofit});
        rows.insert(rows.size(), '{'{FN_FREE, 16'd0, 16'hFFFF}, 1, none});
        rows.insert(rows.size(), '{'{FN_FREE, 16'd0, 16'd3}, 0, nofit});
        rows.insert(rows.size(), '{'{FN_WORST, 16'd600, 16'd0}, 0, nofit});
        rows.insert(rows.size(), '{'{FN_FIRST, 16'd1000, 16'd0}, 0, nofit});
        rows.insert(rows.size(), '{'{FN_NEXT, 16'd1, 16'd0}, 0, nofit});

        region_size = RESET_TOTAL[15:0];
        rebuild_table();
        nf_cursor = 0;
        next_id   = ID_FIRST;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[n])
            issue(rows[n].req, rows[n].typed, rows[n].want);
        write_region(16'd1);
        issue('{FN_FIRST, 16'd2, 16'd0}, 1, nofit);
        issue('{FN_BEST, 16'd1, 16'd0}, 0, nofit);
        issue('{FN_FREE, 16'd0, 16'd0}, 1, none);

        for (int seg = 0; seg < NUM_SEGS; seg++) begin
            gap_pct = (seg < 2) ? 28 : (seg < 4) ? 60 : 0;
            write_region(regions[seg]);
            for (int n = 0; n < SEG_ITEMS; n++) begin
                issue(random_request(), 0, nofit);
                maybe_pause();
            end
        end

        start <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (fail_cnt == 0 && pending_res.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== variable_partition_allocator.f =====
design/vpa_pkg.sv
design/vpa_table.sv
design/variable_partition_allocator.sv
test/tb_variable_partition_allocator.sv
